// ----- rtl/core/vdrle_pkg.sv -----
// Shared types and constants for the vertical delta run-length encoder.
// No dependencies; every other RTL file except vdrle_ram refers to this package by scoped names.
`default_nettype none

package vdrle_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MAX_RUN_DEF   = 127;
    localparam int CFG_W         = 12;
    localparam int BYTE_W        = 8;
    localparam int RUN_W         = 7;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 12'd16;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_ZERO,
        KIND_LIT
    } kind_t;

    typedef enum logic [1:0] {
        PH_OLD,
        PH_MAIN,
        PH_EOP,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RES,
        ST_PLAN,
        ST_HDR,
        ST_LIT,
        ST_EXTRA
    } state_t;

    // byte stream from the sequencer to the packer
    typedef struct packed {
        logic              push;
        logic [BYTE_W-1:0] data;
        logic              finish;
    } byte_req_t;

    typedef struct packed {
        logic byte_ready;
        logic finish_ready;
    } pack_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/vdrle_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module vdrle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/vdrle_packer.sv -----
// Packs the coded byte stream into pairs and holds one result in an output register.
// Depends on vdrle_pkg.
`default_nettype none

module vdrle_packer (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire vdrle_pkg::byte_req_t   req,
    output vdrle_pkg::pack_stat_t       stat,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [vdrle_pkg::BYTE_W-1:0] first_byte,
    output logic [vdrle_pkg::BYTE_W-1:0] second_byte,
    output logic                        second_valid,
    output logic                        last_of_run
);

    typedef enum logic [1:0] {
        FILL_EMPTY,
        FILL_HALF,
        FILL_FULL
    } fill_t;

    fill_t                        fill_reg, fill_next;
    logic [vdrle_pkg::BYTE_W-1:0] st_first_reg, st_first_next;
    logic [vdrle_pkg::BYTE_W-1:0] st_second_reg, st_second_next;
    logic                         out_valid_reg, out_valid_next;
    logic [vdrle_pkg::BYTE_W-1:0] out_first_reg, out_first_next;
    logic [vdrle_pkg::BYTE_W-1:0] out_second_reg, out_second_next;
    logic                         out_sv_reg, out_sv_next;
    logic                         out_last_reg, out_last_next;
    logic                         out_free;
    logic                         load_out;

    assign out_free = !out_valid_reg || out_ready;
    assign stat.byte_ready   = (fill_reg != FILL_FULL) || out_free;
    assign stat.finish_ready = (fill_reg == FILL_EMPTY) || out_free;

    // a staged pair leaves only when the next byte or the end of the item is known,
    // so the last result of an item can carry its flag
    assign load_out = out_free &&
                      ((req.push && fill_reg == FILL_FULL) ||
                       (req.finish && fill_reg != FILL_EMPTY));

    always_comb
    begin
        fill_next      = fill_reg;
        st_first_next  = st_first_reg;
        st_second_next = st_second_reg;
        if (req.push && stat.byte_ready)
        begin
            case (fill_reg)
                FILL_EMPTY:
                begin
                    st_first_next = req.data;
                    fill_next     = FILL_HALF;
                end
                FILL_HALF:
                begin
                    st_second_next = req.data;
                    fill_next      = FILL_FULL;
                end
                default:
                begin
                    st_first_next = req.data;
                    fill_next     = FILL_HALF;
                end
            endcase
        end
        else if (req.finish && stat.finish_ready)
        begin
            fill_next = FILL_EMPTY;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        out_sv_next     = out_sv_reg;
        out_last_next   = out_last_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_first_next  = st_first_reg;
            out_sv_next     = (fill_reg == FILL_FULL);
            out_second_next = (fill_reg == FILL_FULL) ? st_second_reg : '0;
            out_last_next   = req.finish;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= FILL_EMPTY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_first_reg   <= st_first_next;
        st_second_reg  <= st_second_next;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
        out_sv_reg     <= out_sv_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign first_byte   = out_first_reg;
    assign second_byte  = out_second_reg;
    assign second_valid = out_sv_reg;
    assign last_of_run  = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/vdrle_ctrl.sv -----
// Sequencer: row-store read-modify-write, run state, literal store and byte emission.
// Depends on vdrle_pkg; drives the two RAM instances and the packer from the top level.
`default_nettype none

module vdrle_ctrl #(
    parameter int MAX_WIDTH = vdrle_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RUN   = vdrle_pkg::MAX_RUN_DEF,
    parameter int ROW_AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    parameter int LIT_AW    = (MAX_RUN - 1 > 1) ? $clog2(MAX_RUN - 1) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [vdrle_pkg::BYTE_W-1:0]  pixel,
    input  wire logic                          end_of_plane,
    input  wire logic [vdrle_pkg::CFG_W-1:0]   line_width,
    output logic                               row_we,
    output logic [ROW_AW-1:0]                  row_wr_addr,
    output logic [vdrle_pkg::BYTE_W-1:0]       row_wr_data,
    output logic [ROW_AW-1:0]                  row_rd_addr,
    input  wire logic [vdrle_pkg::BYTE_W-1:0]  row_rd_data,
    output logic                               lit_we,
    output logic [LIT_AW-1:0]                  lit_wr_addr,
    output logic [vdrle_pkg::BYTE_W-1:0]       lit_wr_data,
    output logic [LIT_AW-1:0]                  lit_rd_addr,
    input  wire logic [vdrle_pkg::BYTE_W-1:0]  lit_rd_data,
    output vdrle_pkg::byte_req_t               req,
    input  wire vdrle_pkg::pack_stat_t         stat
);

    localparam int RUN_W = vdrle_pkg::RUN_W;
    localparam int BW    = vdrle_pkg::BYTE_W;
    localparam int CMP_W = ((vdrle_pkg::CFG_W > ROW_AW + 1) ? vdrle_pkg::CFG_W : ROW_AW + 1) + 1;

    vdrle_pkg::state_t state_reg, state_next;
    vdrle_pkg::phase_t phase_reg, phase_next;
    vdrle_pkg::kind_t  run_kind_reg, run_kind_next;
    vdrle_pkg::kind_t  res_kind_reg, res_kind_next;
    logic [RUN_W-1:0]  run_count_reg, run_count_next;
    logic [ROW_AW-1:0] column_reg, column_next;
    logic              first_row_reg, first_row_next;
    logic [BW-1:0]     pixel_reg, pixel_next;
    logic              eop_reg, eop_next;
    logic [BW-1:0]     res_reg, res_next;
    logic [BW-1:0]     hdr_reg, hdr_next;
    logic [RUN_W-1:0]  lits_reg, lits_next;
    logic              extra_reg, extra_next;
    logic [RUN_W-1:0]  lit_idx_reg, lit_idx_next;

    logic [CMP_W-1:0]  width_lim;
    logic [CMP_W-1:0]  col_inc;
    logic              wrap;
    logic [BW-1:0]     res_calc;
    logic              hit;
    logic              lit_last;

    function automatic logic [BW-1:0] hdr_byte(input vdrle_pkg::kind_t k,
                                               input logic [RUN_W-1:0] c);
        hdr_byte = {(k == vdrle_pkg::KIND_LIT), c};
    endfunction

    // effective width: 0 acts as 1, anything above the store depth as the depth
    always_comb
    begin
        if (line_width == '0)
        begin
            width_lim = CMP_W'(1);
        end
        else if (CMP_W'(line_width) > CMP_W'(MAX_WIDTH))
        begin
            width_lim = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            width_lim = CMP_W'(line_width);
        end
    end

    assign col_inc  = CMP_W'(column_reg) + CMP_W'(1);
    assign wrap     = col_inc >= width_lim;
    assign res_calc = first_row_reg ? pixel_reg : pixel_reg - row_rd_data;
    // a run at MAX_RUN-1 entries closes with the current byte
    assign hit      = run_count_reg >= RUN_W'(MAX_RUN - 1);
    assign lit_last = lit_idx_reg == (lits_reg - RUN_W'(1));

    // next state and datapath registers
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        run_kind_next  = run_kind_reg;
        res_kind_next  = res_kind_reg;
        run_count_next = run_count_reg;
        column_next    = column_reg;
        first_row_next = first_row_reg;
        pixel_next     = pixel_reg;
        eop_next       = eop_reg;
        res_next       = res_reg;
        hdr_next       = hdr_reg;
        lits_next      = lits_reg;
        extra_next     = extra_reg;
        lit_idx_next   = lit_idx_reg;
        unique case (state_reg)
            vdrle_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    pixel_next = pixel;
                    eop_next   = end_of_plane;
                    state_next = vdrle_pkg::ST_RES;
                end
            end
            vdrle_pkg::ST_RES:
            begin
                res_next      = res_calc;
                res_kind_next = (res_calc == '0) ? vdrle_pkg::KIND_ZERO : vdrle_pkg::KIND_LIT;
                if (eop_reg)
                begin
                    column_next    = '0;
                    first_row_next = 1'b1;
                end
                else if (wrap)
                begin
                    column_next    = '0;
                    first_row_next = 1'b0;
                end
                else
                begin
                    column_next = ROW_AW'(col_inc);
                end
                phase_next = vdrle_pkg::PH_OLD;
                state_next = vdrle_pkg::ST_PLAN;
            end
            vdrle_pkg::ST_PLAN:
            begin
                unique case (phase_reg)
                    vdrle_pkg::PH_OLD:
                    begin
                        phase_next = vdrle_pkg::PH_MAIN;
                        if (run_kind_reg != vdrle_pkg::KIND_NONE && run_kind_reg != res_kind_reg)
                        begin
                            hdr_next       = hdr_byte(run_kind_reg, run_count_reg);
                            lits_next      = (run_kind_reg == vdrle_pkg::KIND_LIT)
                                             ? run_count_reg : '0;
                            extra_next     = 1'b0;
                            run_kind_next  = vdrle_pkg::KIND_NONE;
                            run_count_next = '0;
                            state_next     = vdrle_pkg::ST_HDR;
                        end
                    end
                    vdrle_pkg::PH_MAIN:
                    begin
                        phase_next = vdrle_pkg::PH_EOP;
                        if (hit)
                        begin
                            hdr_next       = hdr_byte(res_kind_reg, RUN_W'(MAX_RUN));
                            lits_next      = (res_kind_reg == vdrle_pkg::KIND_LIT)
                                             ? run_count_reg : '0;
                            extra_next     = (res_kind_reg == vdrle_pkg::KIND_LIT);
                            run_kind_next  = vdrle_pkg::KIND_NONE;
                            run_count_next = '0;
                            state_next     = vdrle_pkg::ST_HDR;
                        end
                        else
                        begin
                            run_kind_next  = res_kind_reg;
                            run_count_next = run_count_reg + RUN_W'(1);
                        end
                    end
                    vdrle_pkg::PH_EOP:
                    begin
                        phase_next = vdrle_pkg::PH_DONE;
                        if (eop_reg && run_kind_reg != vdrle_pkg::KIND_NONE)
                        begin
                            hdr_next       = hdr_byte(run_kind_reg, run_count_reg);
                            lits_next      = (run_kind_reg == vdrle_pkg::KIND_LIT)
                                             ? run_count_reg : '0;
                            extra_next     = 1'b0;
                            run_kind_next  = vdrle_pkg::KIND_NONE;
                            run_count_next = '0;
                            state_next     = vdrle_pkg::ST_HDR;
                        end
                    end
                    vdrle_pkg::PH_DONE:
                    begin
                        if (stat.finish_ready)
                        begin
                            state_next = vdrle_pkg::ST_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = vdrle_pkg::PH_DONE;
                    end
                endcase
            end
            vdrle_pkg::ST_HDR:
            begin
                if (stat.byte_ready)
                begin
                    lit_idx_next = '0;
                    if (lits_reg != '0)
                    begin
                        state_next = vdrle_pkg::ST_LIT;
                    end
                    else if (extra_reg)
                    begin
                        state_next = vdrle_pkg::ST_EXTRA;
                    end
                    else
                    begin
                        state_next = vdrle_pkg::ST_PLAN;
                    end
                end
            end
            vdrle_pkg::ST_LIT:
            begin
                if (stat.byte_ready)
                begin
                    if (lit_last)
                    begin
                        state_next = extra_reg ? vdrle_pkg::ST_EXTRA : vdrle_pkg::ST_PLAN;
                    end
                    else
                    begin
                        lit_idx_next = lit_idx_reg + RUN_W'(1);
                    end
                end
            end
            vdrle_pkg::ST_EXTRA:
            begin
                if (stat.byte_ready)
                begin
                    state_next = vdrle_pkg::ST_PLAN;
                end
            end
            default:
            begin
                state_next = vdrle_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready    = (state_reg == vdrle_pkg::ST_IDLE);
        row_rd_addr = column_reg;
        row_we      = (state_reg == vdrle_pkg::ST_RES);
        row_wr_addr = column_reg;
        row_wr_data = pixel_reg;
        lit_we      = (state_reg == vdrle_pkg::ST_PLAN) && (phase_reg == vdrle_pkg::PH_MAIN) &&
                      !hit && (res_kind_reg == vdrle_pkg::KIND_LIT);
        lit_wr_addr = run_count_reg[LIT_AW-1:0];
        lit_wr_data = res_reg;
        // read one ahead while the current literal is taken; the header state primes entry 0
        lit_rd_addr = '0;
        req.push    = 1'b0;
        req.data    = hdr_reg;
        req.finish  = (state_reg == vdrle_pkg::ST_PLAN) && (phase_reg == vdrle_pkg::PH_DONE);
        unique case (state_reg)
            vdrle_pkg::ST_HDR:
            begin
                req.push = 1'b1;
                req.data = hdr_reg;
            end
            vdrle_pkg::ST_LIT:
            begin
                req.push    = 1'b1;
                req.data    = lit_rd_data;
                lit_rd_addr = (stat.byte_ready && !lit_last)
                              ? LIT_AW'(lit_idx_reg + RUN_W'(1))
                              : LIT_AW'(lit_idx_reg);
            end
            vdrle_pkg::ST_EXTRA:
            begin
                req.push = 1'b1;
                req.data = res_reg;
            end
            default:
            begin
                req.push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vdrle_pkg::ST_IDLE;
            phase_reg     <= vdrle_pkg::PH_OLD;
            run_kind_reg  <= vdrle_pkg::KIND_NONE;
            run_count_reg <= '0;
            column_reg    <= '0;
            first_row_reg <= 1'b1;
            lit_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            run_kind_reg  <= run_kind_next;
            run_count_reg <= run_count_next;
            column_reg    <= column_next;
            first_row_reg <= first_row_next;
            lit_idx_reg   <= lit_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg    <= pixel_next;
        eop_reg      <= eop_next;
        res_reg      <= res_next;
        res_kind_reg <= res_kind_next;
        hdr_reg      <= hdr_next;
        lits_reg     <= lits_next;
        extra_reg    <= extra_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/vertical_delta_run_length_encoder_unit.sv -----
// The sequencer handles one item at a time and takes no new pixel until it has handed the
// item's coded bytes and its finish to the packer, which can hold it back while out_ready is low.
// Reset: control state clears, line_width returns to 16; row and literal RAMs keep
// undefined contents (no clearing pass).
// Top level: config register, row/literal RAMs, sequencer and packer; uses vdrle_pkg.
`default_nettype none

module vertical_delta_run_length_encoder_unit #(
    parameter int MAX_WIDTH = vdrle_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RUN   = vdrle_pkg::MAX_RUN_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [vdrle_pkg::CFG_W-1:0]   line_width,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [vdrle_pkg::BYTE_W-1:0]  pixel,
    input  wire logic                          end_of_plane,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [vdrle_pkg::BYTE_W-1:0]       first_byte,
    output logic [vdrle_pkg::BYTE_W-1:0]       second_byte,
    output logic                               second_valid,
    output logic                               last_of_run
);

    localparam int ROW_AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LIT_DEPTH = MAX_RUN - 1;
    localparam int LIT_AW    = (LIT_DEPTH > 1) ? $clog2(LIT_DEPTH) : 1;
    localparam int BW        = vdrle_pkg::BYTE_W;

    logic [vdrle_pkg::CFG_W-1:0] width_reg;

    logic              row_we;
    logic [ROW_AW-1:0] row_wr_addr;
    logic [BW-1:0]     row_wr_data;
    logic [ROW_AW-1:0] row_rd_addr;
    logic [BW-1:0]     row_rd_data;
    logic              lit_we;
    logic [LIT_AW-1:0] lit_wr_addr;
    logic [BW-1:0]     lit_wr_data;
    logic [LIT_AW-1:0] lit_rd_addr;
    logic [BW-1:0]     lit_rd_data;

    vdrle_pkg::byte_req_t  req;
    vdrle_pkg::pack_stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= vdrle_pkg::WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            width_reg <= line_width;
        end
    end

    vdrle_ram #(
        .WIDTH (BW),
        .DEPTH (MAX_WIDTH),
        .AW    (ROW_AW)
    ) u_row_ram (
        .clk     (clk),
        .we      (row_we),
        .wr_addr (row_wr_addr),
        .wr_data (row_wr_data),
        .rd_addr (row_rd_addr),
        .rd_data (row_rd_data)
    );

    vdrle_ram #(
        .WIDTH (BW),
        .DEPTH (LIT_DEPTH),
        .AW    (LIT_AW)
    ) u_lit_ram (
        .clk     (clk),
        .we      (lit_we),
        .wr_addr (lit_wr_addr),
        .wr_data (lit_wr_data),
        .rd_addr (lit_rd_addr),
        .rd_data (lit_rd_data)
    );

    vdrle_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_RUN   (MAX_RUN),
        .ROW_AW    (ROW_AW),
        .LIT_AW    (LIT_AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel        (pixel),
        .end_of_plane (end_of_plane),
        .line_width   (width_reg),
        .row_we       (row_we),
        .row_wr_addr  (row_wr_addr),
        .row_wr_data  (row_wr_data),
        .row_rd_addr  (row_rd_addr),
        .row_rd_data  (row_rd_data),
        .lit_we       (lit_we),
        .lit_wr_addr  (lit_wr_addr),
        .lit_wr_data  (lit_wr_data),
        .lit_rd_addr  (lit_rd_addr),
        .lit_rd_data  (lit_rd_data),
        .req          (req),
        .stat         (stat)
    );

    vdrle_packer u_packer (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .first_byte   (first_byte),
        .second_byte  (second_byte),
        .second_valid (second_valid),
        .last_of_run  (last_of_run)
    );

`ifndef ASSERT_OFF
    a_push_or_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.push && req.finish))
        else $error("byte push and item finish in the same cycle");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item accepted while one is in work");

    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.finish && stat.finish_ready) |=> in_ready)
        else $error("sequencer not idle after item finish");

    a_lit_addr: assert property (@(posedge clk) disable iff (!rst_n)
        lit_we |-> (32'(lit_wr_addr) < LIT_DEPTH))
        else $error("literal write beyond store depth");

    a_row_addr: assert property (@(posedge clk) disable iff (!rst_n)
        row_we |-> (32'(row_wr_addr) < MAX_WIDTH))
        else $error("row write beyond store depth");
`endif

endmodule

`default_nettype wire

// ----- bench/vertical_delta_run_length_encoder_unit_tb.sv -----
// Self-checking bench for vertical_delta_run_length_encoder_unit: a table of directed pixels,
// then random planes, checked against an in-bench predictor of the coded byte pairs or, for
// table steps marked known, against the pair in the table. Depends on vdrle_pkg and the encoder RTL only.

module vertical_delta_run_length_encoder_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ROW_MAX       = vdrle_pkg::MAX_WIDTH_DEF;
    localparam int unsigned RUN_MAX       = vdrle_pkg::MAX_RUN_DEF;
    localparam logic [7:0]  LIT_FLAG      = 8'h80;
    localparam int unsigned SETTLE_CYCLES = 32;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned CYCLE_LIMIT   = 300000;

    typedef struct packed {
        logic [7:0] lead;
        logic [7:0] trail;
        logic       trail_ok;
        logic       ends_item;
    } pair_t;

    typedef enum logic {
        STEP_PIXEL,
        STEP_WIDTH
    } step_op_t;

    // known = 1: the single result of the row is written out below
    typedef struct packed {
        step_op_t   op;
        logic [11:0] value;
        logic       eop;
        logic [7:0] reps;
        logic       known;
        logic [7:0] lead;
        logic [7:0] trail;
        logic       trail_ok;
    } step_t;

    step_t directed_steps [27] = '{
        '{STEP_PIXEL, 12'h000, 1'b1, 8'd1,   1'b1, 8'h01, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h0FF, 1'b1, 8'd1,   1'b1, 8'h81, 8'hFF, 1'b1},
        '{STEP_PIXEL, 12'h080, 1'b0, 8'd2,   1'b0, 8'h00, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h000, 1'b0, 8'd1,   1'b0, 8'h00, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h000, 1'b1, 8'd1,   1'b0, 8'h00, 8'h00, 1'b0},
        // width 0 behaves as a one-pixel row
        '{STEP_WIDTH, 12'h000, 1'b0, 8'd1,   1'b0, 8'h00, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h010, 1'b0, 8'd1,   1'b0, 8'h00, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h010, 1'b0, 8'd1,   1'b1, 8'h81, 8'h10, 1'b1},
        '{STEP_PIXEL, 12'h00F, 1'b0, 8'd1,   1'b1, 8'h01, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h010, 1'b1, 8'd1,   1'b0, 8'h00, 8'h00, 1'b0},
        '{STEP_WIDTH, 12'h003, 1'b0, 8'd1,   1'b0, 8'h00, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h005, 1'b0, 8'd1,   1'b0, 8'h00, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h006, 1'b0, 8'd1,   1'b0, 8'h00, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h007, 1'b0, 8'd1,   1'b0, 8'h00, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h005, 1'b0, 8'd1,   1'b0, 8'h00, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h006, 1'b0, 8'd1,   1'b0, 8'h00, 8'h00, 1'b0},
        // shrink mid-plane: column 2 is past the new width and wraps after this pixel
        '{STEP_WIDTH, 12'h002, 1'b0, 8'd1,   1'b0, 8'h00, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h009, 1'b0, 8'd1,   1'b0, 8'h00, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h005, 1'b0, 8'd1,   1'b0, 8'h00, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h006, 1'b1, 8'd1,   1'b0, 8'h00, 8'h00, 1'b0},
        // above the maximum: clamps to the widest row
        '{STEP_WIDTH, 12'hFFF, 1'b0, 8'd1,   1'b0, 8'h00, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h000, 1'b0, 8'd8,   1'b0, 8'h00, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h000, 1'b1, 8'd1,   1'b0, 8'h00, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h0A5, 1'b1, 8'd3,   1'b0, 8'h00, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h03C, 1'b1, 8'd1,   1'b1, 8'h81, 8'h3C, 1'b1},
        '{STEP_WIDTH, 12'h800, 1'b0, 8'd1,   1'b0, 8'h00, 8'h00, 1'b0},
        '{STEP_PIXEL, 12'h07F, 1'b1, 8'd1,   1'b1, 8'h81, 8'h7F, 1'b1}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] line_width;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  pixel;
    logic        end_of_plane;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic        second_valid;
    logic        last_of_run;

    // predictor state
    logic [11:0]       width_reg;
    logic [7:0]        prev_row [0:ROW_MAX-1];
    int unsigned       col;
    bit                first_row;
    vdrle_pkg::kind_t  open_kind;
    int unsigned       open_len;
    logic [7:0]        lit_buf [0:RUN_MAX-2];
    logic [7:0]        coded [$];
    pair_t             expected_pairs [$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    logic        hold_off;
    event        hold_start;
    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned pixels_sent;
    int unsigned pairs_checked;
    int unsigned width_writes;

    vertical_delta_run_length_encoder_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .line_width   (line_width),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel        (pixel),
        .end_of_plane (end_of_plane),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .first_byte   (first_byte),
        .second_byte  (second_byte),
        .second_valid (second_valid),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void flush_run();
        int unsigned i;
        if (open_kind == vdrle_pkg::KIND_ZERO)
        begin
            coded.push_back(8'(open_len));
        end
        else if (open_kind == vdrle_pkg::KIND_LIT)
        begin
            coded.push_back(LIT_FLAG | 8'(open_len));
            for (i = 0; i < open_len; i++)
                coded.push_back(lit_buf[i]);
        end
        open_kind = vdrle_pkg::KIND_NONE;
        open_len  = 0;
    endfunction

    function automatic void code_residual(input logic [7:0] r);
        vdrle_pkg::kind_t k;
        int unsigned      i;
        k = (r == 8'h00) ? vdrle_pkg::KIND_ZERO : vdrle_pkg::KIND_LIT;
        if (open_kind != k)
            flush_run();
        open_kind = k;
        if (open_len + 1 >= RUN_MAX)
        begin
            // run is full: this residual goes straight out with it
            if (k == vdrle_pkg::KIND_ZERO)
            begin
                open_len = RUN_MAX;
                flush_run();
            end
            else
            begin
                coded.push_back(LIT_FLAG | 8'(RUN_MAX));
                for (i = 0; i < open_len; i++)
                    coded.push_back(lit_buf[i]);
                coded.push_back(r);
                open_kind = vdrle_pkg::KIND_NONE;
                open_len  = 0;
            end
        end
        else
        begin
            if (k == vdrle_pkg::KIND_LIT)
                lit_buf[open_len] = r;
            open_len++;
        end
    endfunction

    // Codes one accepted pixel; keep = 0 updates state without queuing the pairs.
    function automatic void encode_pixel(input logic [7:0] p, input logic eop, input bit keep);
        int unsigned w;
        int unsigned n;
        int unsigned k;
        logic [7:0]  r;
        pair_t       pr;
        w = width_reg;
        if (w == 0)
            w = 1;
        if (w > ROW_MAX)
            w = ROW_MAX;
        coded.delete();
        r = first_row ? p : 8'(p - prev_row[col]);
        prev_row[col] = p;
        code_residual(r);
        col = col + 1;
        if (col >= w)
        begin
            col       = 0;
            first_row = 1'b0;
        end
        if (eop)
        begin
            flush_run();
            col       = 0;
            first_row = 1'b1;
        end
        n = (coded.size() + 1) / 2;
        for (k = 0; k < n; k++)
        begin
            pr.lead      = coded[2*k];
            pr.trail_ok  = (2*k + 1 < coded.size());
            pr.trail     = pr.trail_ok ? coded[2*k + 1] : 8'h00;
            pr.ends_item = (k + 1 == n);
            if (keep)
                expected_pairs.push_back(pr);
        end
    endfunction

    task automatic offer_pixel(input logic [7:0] p, input logic eop, input bit keep);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        pixel        <= p;
        end_of_plane <= eop;
        do @(posedge clk); while (!in_ready);
        encode_pixel(p, eop, keep);
        pixels_sent++;
    endtask

    // Written only once the encoder has drained and gone quiet.
    task automatic set_width(input logic [11:0] w);
        in_valid <= 1'b0;
        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid  <= 1'b1;
        line_width <= w;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        width_reg = w;
        width_writes++;
    endtask

    task automatic random_phase(input int unsigned n_items, input int unsigned idle_pct,
                                input int unsigned stall_pct, input bit squeeze);
        int unsigned w;
        int unsigned sent;
        int unsigned plane_len;
        int unsigned calm_pct;
        int unsigned k;
        logic [7:0]  p;
        w = ($urandom_range(4) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        set_width(12'(w));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (squeeze)
            -> hold_start;
        sent = 0;
        while (sent < n_items)
        begin
            plane_len = $urandom_range(1, (w < 8) ? 4 * w : 30);
            case ($urandom_range(2))
                0:       calm_pct = 10;
                1:       calm_pct = 50;
                default: calm_pct = 90;
            endcase
            if (squeeze)
                calm_pct = 10;
            // calm pixels repeat the one above, giving zero residuals
            for (k = 0; k < plane_len; k++)
            begin
                if ($urandom_range(99) < calm_pct)
                    p = first_row ? 8'h00 : prev_row[col];
                else if (!first_row && $urandom_range(1) == 1)
                    p = prev_row[col] + 8'($urandom_range(1, 3));
                else
                    p = 8'($urandom);
                offer_pixel(p, logic'(k == plane_len - 1), 1'b1);
            end
            sent += plane_len;
        end
    endtask

    function automatic void compare_field(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%02h, got 0x%02h", field, want, got);
            mismatches++;
        end
    endfunction

    // output side: random stalls plus the long hold-off
    initial
    begin
        pair_t want;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_pairs.size() == 0)
                begin
                    $error("result 0x%02h 0x%02h with nothing expected", first_byte, second_byte);
                    mismatches++;
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    compare_field("first_byte", want.lead, first_byte);
                    compare_field("second_byte", want.trail, second_byte);
                    compare_field("second_valid", 8'(want.trail_ok), 8'(second_valid));
                    compare_field("last_of_run", 8'(want.ends_item), 8'(last_of_run));
                    pairs_checked++;
                end
            end
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        hold_off = 1'b0;
        forever
        begin
            @(hold_start);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d pairs still expected",
                 cycle_count, expected_pairs.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int unsigned i;
        int unsigned rep;
        pair_t       want;

        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        line_width     = 12'd0;
        in_valid       = 1'b0;
        pixel          = 8'h00;
        end_of_plane   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        pixels_sent    = 0;
        pairs_checked  = 0;
        width_writes   = 0;
        width_reg      = vdrle_pkg::WIDTH_RESET;
        col            = 0;
        first_row      = 1'b1;
        open_kind      = vdrle_pkg::KIND_NONE;
        open_len       = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < $size(directed_steps); i++)
        begin
            if (directed_steps[i].op == STEP_WIDTH)
            begin
                set_width(directed_steps[i].value);
            end
            else
            begin
                for (rep = 0; rep < directed_steps[i].reps; rep++)
                begin
                    offer_pixel(directed_steps[i].value[7:0], directed_steps[i].eop,
                                !directed_steps[i].known);
                    if (directed_steps[i].known)
                    begin
                        want.lead      = directed_steps[i].lead;
                        want.trail     = directed_steps[i].trail;
                        want.trail_ok  = directed_steps[i].trail_ok;
                        want.ends_item = 1'b1;
                        expected_pairs.push_back(want);
                    end
                end
            end
        end

        random_phase(12, 0, 0, 1'b0);
        random_phase(12, 65, 0, 1'b0);
        random_phase(12, 0, 65, 1'b0);
        random_phase(12, 37, 37, 1'b0);
        random_phase(12, 0, 0, 1'b1);

        in_valid <= 1'b0;
        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("coded %0d pixels into %0d byte pairs across %0d line width writes,",
                 pixels_sent, pairs_checked, width_writes);
        $display("including zero and clamped widths, a mid-plane shrink and a %0d-cycle hold",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
